@@ hw/rtl/spps_pkg.sv @@
// shared types and constants for the stable positive partition sort
// no dependencies

package spps_pkg;

	localparam int VAL_W     = 16;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic insert;
		logic pop;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fill_next;
		logic one_left;
	} status_t;

endpackage

@@ hw/rtl/stable_positive_partition_sort.sv @@
// top level of the stable positive partition sort
// depends on spps_pkg, spps_ctrl and spps_datapath

// Loads a list of signed values, one transfer per cycle, until an item marked
// last arrives or the list reaches DEPTH items. Each item is placed on arrival
// into a row of DEPTH cells kept in output order: non-positive values in
// descending order, then positive values in arrival order. After the closing
// item the input is stalled and the list is shifted out of cell zero, one
// transfer per cycle while res_stall is low, the final one marked last_res; a
// new list is taken from the cycle after the final result transfer.

module stable_positive_partition_sort
	import spps_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic signed [VAL_W-1:0] value_res,
	output logic                    last_res
);

	cmd_t    cmd;
	status_t status;

	spps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (last),
		.res_stall  (res_stall),
		.status     (status),
		.item_stall (item_stall),
		.res_valid  (res_valid),
		.cmd        (cmd)
	);

	spps_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (value),
		.status (status),
		.head   (value_res)
	);

	assign last_res = status.one_left;

	// no input taken while results are pending
	a_no_overlap : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> item_stall)
		else $error("input open during output run");

	// a closing item starts the output run
	a_run_starts : assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && last) |=> res_valid)
		else $error("no output run after closing item");

	// the run ends after the final result transfer
	a_run_ends : assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && last_res) |=> !res_valid)
		else $error("output continues past final result");

endmodule

@@ hw/rtl/spps_datapath.sv @@
// insertion chain holding the list in output order, plus element count
// depends on spps_pkg

module spps_datapath
	import spps_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic signed [VAL_W-1:0] value,
	output status_t                 status,
	output logic signed [VAL_W-1:0] head
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic signed [VAL_W-1:0] cell_q [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic [DEPTH-1:0]        keep;
	logic [CNT_W-1:0]        count_q;

	// a cell keeps its place when its element goes before the new one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			keep[i] = vld_q[i] && ((value > 0) || ((cell_q[i] <= 0) && (cell_q[i] >= value)));
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                    prev_keep;
		logic                    prev_vld;
		logic signed [VAL_W-1:0] prev_val;
		logic                    next_vld;
		logic signed [VAL_W-1:0] next_val;

		if (g == 0) begin : g_first
			assign prev_keep = 1'b0;
			assign prev_vld  = 1'b1;
			assign prev_val  = value;
		end else begin : g_rest
			assign prev_keep = keep[g-1];
			assign prev_vld  = vld_q[g-1];
			assign prev_val  = cell_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign next_vld = 1'b0;
			assign next_val = cell_q[g];
		end else begin : g_mid
			assign next_vld = vld_q[g+1];
			assign next_val = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				if (!keep[g]) begin
					cell_q[g] <= prev_keep ? value : prev_val;
				end
			end else if (cmd.pop) begin
				cell_q[g] <= next_val;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (cmd.insert) begin
				vld_q[g] <= vld_q[g] | prev_vld;
			end else if (cmd.pop) begin
				vld_q[g] <= next_vld;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign status.fill_next = (count_q == CNT_W'(DEPTH - 1));
	assign status.one_left  = (count_q == CNT_W'(1));
	assign head             = cell_q[0];

endmodule

@@ hw/rtl/spps_ctrl.sv @@
// load / drain controller for the partition sort
// depends on spps_pkg

module spps_ctrl
	import spps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_last,
	input  logic    res_stall,
	input  status_t status,
	output logic    item_stall,
	output logic    res_valid,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		res_valid  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_LOAD: begin
				item_stall = 1'b0;
				cmd.insert = item_valid;
				if (item_valid && (item_last || status.fill_next)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				res_valid = 1'b1;
				cmd.pop   = !res_stall;
				if (!res_stall && status.one_left) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
